// ===== rtl/core/pndc_pkg.sv =====
// ----------------------------------------------------------------------------
// pndc_pkg
// Shared constants, codes, state type and tanh table entry function for the
// proximity neural drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pndc_pkg;

    localparam int NUM_INPUTS_DEF   = 8;
    localparam int MAX_HIDDEN_DEF   = 8;
    localparam int WEIGHT_DEPTH_DEF = 128;
    localparam int TANH_ENTRIES_DEF = 256;

    localparam int SENSOR_W   = 12;
    localparam int ACT_W      = 15;
    localparam int WEIGHT_W   = 16;
    localparam int SPEED_W    = 11;
    localparam int SCALE_W    = 10;
    localparam int ACC_W      = 40;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 40;

    // tdata layout of the input beat
    localparam int IDX_LSB    = 0;
    localparam int VAL_LSB    = 7;
    localparam int SENSOR_LSB = 23;

    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] OP_LOAD_OFFSET = 2'd1;
    localparam logic [1:0] OP_EVALUATE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_RECIP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OBST_THRESH  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_TANH_MAG,
        ST_TANH_IDX,
        ST_TANH_OUT,
        ST_SPEED
    } mac_state_t;

    localparam longint Q30_ONE = 64'sd1 << 30;

    // restoring divide for nonnegative operands, used when building the table
    function automatic longint udiv(input longint n, input longint d);
        longint q;
        longint r;
        int     b;
        q = 0;
        r = 0;
        for (b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((n >>> b) & 64'sd1);
            if (r >= d) begin
                r = r - d;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // t is x/4 in Q30; result is round(32768*tanh(x)) capped, x = 4i/entries
    function automatic logic [ACT_W-1:0] tanh_entry(input longint t);
        longint term;
        longint sum;
        longint e;
        longint num;
        longint den;
        longint v;
        int     k;
        int     n;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (k = 1; k <= 20; k++) begin
            term = udiv((term * t) >>> 30, longint'(k));
            if ((k & 1) == 1) sum = sum - term;
            else              sum = sum + term;
        end
        e = (sum < 0) ? 64'sd0 : sum;
        for (n = 0; n < 3; n++) e = (e * e) >>> 30;
        num = (Q30_ONE - e) * 32768;
        den = Q30_ONE + e;
        v   = udiv(num + (den >>> 1), den);
        if (v > 32767) v = 32767;
        if (v < 0)     v = 0;
        return v[ACT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pndc_lane.sv =====
// ----------------------------------------------------------------------------
// pndc_lane
// One sensor lane: offset removal, clamp at zero, unsigned Q0.15 normalization and
// obstacle compare.
// ----------------------------------------------------------------------------
`default_nettype none

module pndc_lane
    import pndc_pkg::*;
(
    input  wire logic [SENSOR_W-1:0] sensor,
    input  wire logic [SENSOR_W-1:0] offset,
    input  wire logic [15:0]         range_reciprocal,
    input  wire logic [SENSOR_W-1:0] obst_limit,
    output logic      [ACT_W-1:0]    act,
    output logic                     over
);

    logic [SENSOR_W-1:0]    diff;
    logic [SENSOR_W+15:0]   scaled;
    logic [SENSOR_W+14:0]   half;

    always_comb begin
        diff   = (sensor > offset) ? sensor - offset : '0;
        scaled = (SENSOR_W+16)'(diff) * (SENSOR_W+16)'(range_reciprocal);
        half   = scaled[SENSOR_W+15:1];
        act    = (half > (SENSOR_W+15)'(32767)) ? ACT_W'(32767) : half[ACT_W-1:0];
        over   = diff > obst_limit;
    end

endmodule

`default_nettype wire

// ===== rtl/core/pndc_merge.sv =====
// ----------------------------------------------------------------------------
// pndc_merge
// Registers the lane results of an evaluate beat, then folds them into the
// maximum activation and the obstacle flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pndc_merge
    import pndc_pkg::*;
#(
    parameter int NUM_INPUTS = NUM_INPUTS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             capture,
    input  wire logic [ACT_W-1:0] lane_act [NUM_INPUTS],
    input  wire logic             lane_over [NUM_INPUTS],
    output logic      [ACT_W-1:0] act [NUM_INPUTS],
    output logic      [ACT_W-1:0] max_act,
    output logic                  flag,
    output logic                  start,
    output logic                  busy
);

    logic [ACT_W-1:0] act_reg [NUM_INPUTS];
    logic             over_reg [NUM_INPUTS];
    logic [ACT_W-1:0] max_reg;
    logic             flag_reg;
    logic             start_reg;
    logic [ACT_W-1:0] max_next;
    logic             flag_next;

    always_comb begin
        max_next  = '0;
        flag_next = 1'b0;
        for (int j = 0; j < NUM_INPUTS; j++) begin
            if (act_reg[j] > max_next) max_next = act_reg[j];
            flag_next = flag_next | over_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b0;
        end else begin
            start_reg <= capture;
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            act_reg  <= lane_act;
            over_reg <= lane_over;
        end
        if (start_reg) begin
            max_reg  <= max_next;
            flag_reg <= flag_next;
        end
    end

    assign act     = act_reg;
    assign max_act = max_reg;
    assign flag    = flag_reg;
    assign start   = start_reg;
    assign busy    = start_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pndc_mac.sv =====
// ----------------------------------------------------------------------------
// pndc_mac
// Network sequencer: weight memory, one shared multiply-accumulate pipeline,
// tanh lookup, hidden activation store, speed scaling and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pndc_mac
    import pndc_pkg::*;
#(
    parameter int NUM_INPUTS   = NUM_INPUTS_DEF,
    parameter int MAX_HIDDEN   = MAX_HIDDEN_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF,
    parameter int TANH_ENTRIES = TANH_ENTRIES_DEF,
    localparam int AW  = $clog2(WEIGHT_DEPTH),
    localparam int HW  = $clog2(MAX_HIDDEN + 1),
    localparam int TW  = $clog2(((NUM_INPUTS > MAX_HIDDEN) ? NUM_INPUTS : MAX_HIDDEN) + 1),
    localparam int IIX = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1,
    localparam int HIX = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1,
    localparam int TIX = $clog2(TANH_ENTRIES),
    localparam int TEW = $clog2(TANH_ENTRIES + 1),
    localparam int MW  = ACC_W - 15
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [ACT_W-1:0]    act [NUM_INPUTS],
    input  wire logic [ACT_W-1:0]    max_act,
    input  wire logic                flag,
    input  wire logic [3:0]          hidden_count,
    input  wire logic [SCALE_W-1:0]  speed_scale,
    input  wire logic [ACT_W-1:0]    stop_level,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire logic [WEIGHT_W-1:0] wr_data,
    input  wire logic                m_tready,
    output logic                     busy,
    output logic                     m_tvalid,
    output logic      [SPEED_W-1:0]  m_left,
    output logic      [SPEED_W-1:0]  m_right,
    output logic      [ACT_W-1:0]    m_max,
    output logic                     m_flag
);

    logic [ACT_W-1:0] tanh_tab [TANH_ENTRIES];

    for (genvar i = 0; i < TANH_ENTRIES; i++) begin : g_tab
        localparam longint TT = (longint'(i) << 30) / TANH_ENTRIES;
        assign tanh_tab[i] = tanh_entry(TT);
    end

    logic [WEIGHT_W-1:0] wmem [WEIGHT_DEPTH];

    mac_state_t                 state_reg, state_next;
    logic                       layer_reg, layer_next;     // 1 = output layer
    logic [HW-1:0]              neuron_reg, neuron_next;
    logic [HW-1:0]              h_reg, h_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [TW-1:0]              issue_reg, issue_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]           mag_reg, mag_next;
    logic                       neg_reg, neg_next;
    logic [TIX-1:0]             tidx_reg, tidx_next;
    logic                       sat_reg, sat_next;
    logic                       m_valid_reg, m_valid_next;

    logic                       p1_valid_reg;
    logic [TW-1:0]              p1_idx_reg;
    logic [WEIGHT_W-1:0]        rdata_reg;
    logic                       p2_valid_reg;
    logic signed [32:0]         prod_reg;

    logic signed [WEIGHT_W-1:0] hid_reg [MAX_HIDDEN];
    logic signed [WEIGHT_W-1:0] outv_reg [2];
    logic [SPEED_W-1:0]         left_reg, right_reg;
    logic [ACT_W-1:0]           max_reg;
    logic                       flag_reg;

    logic                       use_act;
    logic [TW-1:0]              count;
    logic signed [16:0]         operand;
    logic [HW-1:0]              h_clamp;
    logic [MW+TEW-1:0]          tprod;
    logic [MW+TEW-15:0]         tq;
    logic [ACT_W-1:0]           tval;
    logic signed [WEIGHT_W-1:0] tres;
    logic                       hid_we;
    logic                       out_we;
    logic                       res_we;
    logic [SPEED_W-1:0]         left_sp, right_sp;

    function automatic logic [SPEED_W-1:0] to_speed(input logic signed [WEIGHT_W-1:0] v,
                                                    input logic [SCALE_W-1:0] scale);
        logic [WEIGHT_W-1:0]        mag;
        logic [ACT_W+SCALE_W-1:0]   p;
        logic [SPEED_W-1:0]         s;
        mag = (v < 0) ? WEIGHT_W'(-v) : WEIGHT_W'(v);
        p   = (ACT_W+SCALE_W)'(mag[ACT_W-1:0]) * (ACT_W+SCALE_W)'(scale);
        s   = {1'b0, p[ACT_W+SCALE_W-1:ACT_W]};
        return (v < 0) ? SPEED_W'(-s) : s;
    endfunction

    always_comb begin
        h_clamp = (int'(hidden_count) > MAX_HIDDEN) ? HW'(MAX_HIDDEN) : HW'(hidden_count);
        use_act = !layer_reg || (h_reg == '0);
        count   = use_act ? TW'(NUM_INPUTS) : TW'(h_reg);

        if (p1_idx_reg == count) begin
            operand = 17'sh08000;              // bias term, weight * 2^15
        end else if (use_act) begin
            operand = $signed({2'b00, act[p1_idx_reg[IIX-1:0]]});
        end else begin
            operand = 17'(hid_reg[p1_idx_reg[HIX-1:0]]);
        end

        tprod = (MW+TEW)'(mag_reg[ACC_W-1:15]) * (MW+TEW)'(TANH_ENTRIES);
        tq    = tprod[MW+TEW-1:14];
        tval  = sat_reg ? ACT_W'(32767) : tanh_tab[tidx_reg];
        tres  = neg_reg ? -$signed({1'b0, tval}) : $signed({1'b0, tval});

        left_sp  = (max_act > stop_level) ? '0 : to_speed(outv_reg[0], speed_scale);
        right_sp = (max_act > stop_level) ? '0 : to_speed(outv_reg[1], speed_scale);
    end

    always_comb begin
        state_next   = state_reg;
        layer_next   = layer_reg;
        neuron_next  = neuron_reg;
        h_next       = h_reg;
        ptr_next     = ptr_reg;
        issue_next   = issue_reg;
        acc_next     = p2_valid_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        tidx_next    = tidx_reg;
        sat_next     = sat_reg;
        m_valid_next = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;
        hid_we       = 1'b0;
        out_we       = 1'b0;
        res_we       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    h_next      = h_clamp;
                    layer_next  = (h_clamp == '0);
                    neuron_next = '0;
                    ptr_next    = '0;
                    issue_next  = '0;
                    acc_next    = '0;
                    state_next  = ST_MAC;
                end
            end
            ST_MAC: begin
                // weights of all neurons sit back to back from address zero
                ptr_next = (int'(ptr_reg) == WEIGHT_DEPTH - 1) ? '0 : ptr_reg + 1'b1;
                if (issue_reg == count) state_next = ST_DRAIN;
                else                    issue_next = issue_reg + 1'b1;
            end
            ST_DRAIN: begin
                if (!p1_valid_reg && !p2_valid_reg) state_next = ST_TANH_MAG;
            end
            ST_TANH_MAG: begin
                neg_next   = acc_reg < 0;
                mag_next   = (acc_reg < 0) ? $unsigned(-acc_reg) : $unsigned(acc_reg);
                state_next = ST_TANH_IDX;
            end
            ST_TANH_IDX: begin
                sat_next   = tq >= (MW+TEW-14)'(TANH_ENTRIES);
                tidx_next  = tq[TIX-1:0];
                state_next = ST_TANH_OUT;
            end
            ST_TANH_OUT: begin
                acc_next   = '0;
                issue_next = '0;
                state_next = ST_MAC;
                if (!layer_reg) begin
                    hid_we = 1'b1;
                    if (neuron_reg == h_reg - 1'b1) begin
                        layer_next  = 1'b1;
                        neuron_next = '0;
                    end else begin
                        neuron_next = neuron_reg + 1'b1;
                    end
                end else begin
                    out_we = 1'b1;
                    if (neuron_reg[0]) state_next = ST_SPEED;
                    else               neuron_next = neuron_reg + 1'b1;
                end
            end
            ST_SPEED: begin
                if (!m_valid_reg || m_tready) begin
                    res_we       = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            p1_valid_reg <= (state_reg == ST_MAC);
            p2_valid_reg <= p1_valid_reg;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        layer_reg  <= layer_next;
        neuron_reg <= neuron_next;
        h_reg      <= h_next;
        ptr_reg    <= ptr_next;
        issue_reg  <= issue_next;
        acc_reg    <= acc_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        tidx_reg   <= tidx_next;
        sat_reg    <= sat_next;
        p1_idx_reg <= issue_reg;
        prod_reg   <= operand * $signed(rdata_reg);
        if (hid_we) hid_reg[neuron_reg[HIX-1:0]] <= tres;
        if (out_we) outv_reg[neuron_reg[0]]       <= tres;
        if (res_we) begin
            left_reg  <= left_sp;
            right_reg <= right_sp;
            max_reg   <= max_act;
            flag_reg  <= flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) wmem[wr_addr] <= wr_data;
        rdata_reg <= wmem[ptr_reg];
    end

    assign busy     = (state_reg != ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_left   = left_reg;
    assign m_right  = right_reg;
    assign m_max    = max_reg;
    assign m_flag   = flag_reg;

endmodule

`default_nettype wire

// ===== rtl/core/proximity_neural_drive_controller_core.sv =====
// ----------------------------------------------------------------------------
// proximity_neural_drive_controller_core
// Proximity sensor front end and small perceptron giving two wheel speeds.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the op. Load beats (weight, sensor offset)
// give no result. An evaluate beat gives one result beat on the m_ stream.
// Op 3 is dropped.
// Config port: cfg_wr_en/cfg_index/cfg_wdata, to be written only while the
// block idles; the block itself does not enforce this.
// An evaluate runs each neuron as a weighted sum of its fan_in terms plus a
// bias, then a tanh lookup; a neuron's fan_in is 8 inputs for hidden neurons
// and for outputs with no hidden layer (reset value), else the hidden count.
// All products run through one multiplier fed by the weight memory's single
// read port, one term a cycle.
// s_tready drops while an evaluate is in flight, one item at a time; it rises
// again in the cycle the result is loaded into the output register.
// The result sits in an output register; a stalled receiver holds it and
// the next item may still enter, but its result waits until the register
// is taken. Reset clears configuration to defaults and offsets to zero;
// weights are unknown until loaded.
`default_nettype none

module proximity_neural_drive_controller_core
    import pndc_pkg::*;
#(
    parameter int NUM_INPUTS   = NUM_INPUTS_DEF,
    parameter int MAX_HIDDEN   = MAX_HIDDEN_DEF,
    parameter int WEIGHT_DEPTH = WEIGHT_DEPTH_DEF,
    parameter int TANH_ENTRIES = TANH_ENTRIES_DEF,
    localparam int AW  = $clog2(WEIGHT_DEPTH),
    localparam int OIX = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // table_index[6:0], table_value[22:7], sensor_0..sensor_7 12 bits each
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // op[1:0]
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // left_speed[10:0], right_speed[21:11], max_activation[36:22],
    // obstacle_flag[37], zero fill
    output logic      [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    logic [3:0]          hidden_count_reg;
    logic [15:0]         range_recip_reg;
    logic [SCALE_W-1:0]  speed_scale_reg;
    logic [ACT_W-1:0]    stop_level_reg;
    logic [SENSOR_W-1:0] obst_thresh_reg;
    logic [SENSOR_W-1:0] offset_reg [NUM_INPUTS];

    logic                accept;
    logic                merge_busy;
    logic                mac_busy;
    logic                start;
    logic                capture;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [6:0]          idx;
    logic [6:0]          idx_mod;
    logic [ACT_W-1:0]    lane_act [NUM_INPUTS];
    logic                lane_over [NUM_INPUTS];
    logic [ACT_W-1:0]    act [NUM_INPUTS];
    logic [ACT_W-1:0]    max_act;
    logic                flag;
    logic [SPEED_W-1:0]  m_left, m_right;
    logic [ACT_W-1:0]    m_max;
    logic                m_flag;

    assign s_tready = !merge_busy && !mac_busy;
    assign accept   = s_tvalid && s_tready;
    assign idx      = s_tdata[IDX_LSB +: 7];
    assign capture  = accept && (s_tuser == OP_EVALUATE);
    assign wr_en    = accept && (s_tuser == OP_LOAD_WEIGHT);

    // weight address wraps at the memory depth
    always_comb begin
        idx_mod = idx;
        for (int k = 0; k < 4; k++) begin
            if (int'(idx_mod) >= WEIGHT_DEPTH) idx_mod = idx_mod - 7'(WEIGHT_DEPTH);
        end
        wr_addr = AW'(idx_mod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hidden_count_reg <= 4'd0;
            range_recip_reg  <= 16'd17;
            speed_scale_reg  <= SCALE_W'(1000);
            stop_level_reg   <= ACT_W'(29491);
            obst_thresh_reg  <= SENSOR_W'(300);
            for (int j = 0; j < NUM_INPUTS; j++) offset_reg[j] <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HIDDEN_COUNT: hidden_count_reg <= cfg_wdata[3:0];
                    CFG_RANGE_RECIP:  range_recip_reg  <= cfg_wdata;
                    CFG_SPEED_SCALE:  speed_scale_reg  <= cfg_wdata[SCALE_W-1:0];
                    CFG_STOP_LEVEL:   stop_level_reg   <= cfg_wdata[ACT_W-1:0];
                    CFG_OBST_THRESH:  obst_thresh_reg  <= cfg_wdata[SENSOR_W-1:0];
                    default: ;
                endcase
            end
            if (accept && (s_tuser == OP_LOAD_OFFSET) && (int'(idx) < NUM_INPUTS)) begin
                offset_reg[idx[OIX-1:0]] <= s_tdata[VAL_LSB +: SENSOR_W];
            end
        end
    end

    for (genvar j = 0; j < NUM_INPUTS; j++) begin : g_lane
        pndc_lane u_lane (
            .sensor           (s_tdata[SENSOR_LSB + SENSOR_W*j +: SENSOR_W]),
            .offset           (offset_reg[j]),
            .range_reciprocal (range_recip_reg),
            .obst_limit       (obst_thresh_reg),
            .act              (lane_act[j]),
            .over             (lane_over[j])
        );
    end

    pndc_merge #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .capture   (capture),
        .lane_act  (lane_act),
        .lane_over (lane_over),
        .act       (act),
        .max_act   (max_act),
        .flag      (flag),
        .start     (start),
        .busy      (merge_busy)
    );

    pndc_mac #(
        .NUM_INPUTS   (NUM_INPUTS),
        .MAX_HIDDEN   (MAX_HIDDEN),
        .WEIGHT_DEPTH (WEIGHT_DEPTH),
        .TANH_ENTRIES (TANH_ENTRIES)
    ) u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .act          (act),
        .max_act      (max_act),
        .flag         (flag),
        .hidden_count (hidden_count_reg),
        .speed_scale  (speed_scale_reg),
        .stop_level   (stop_level_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (s_tdata[VAL_LSB +: WEIGHT_W]),
        .m_tready     (m_tready),
        .busy         (mac_busy),
        .m_tvalid     (m_tvalid),
        .m_left       (m_left),
        .m_right      (m_right),
        .m_max        (m_max),
        .m_flag       (m_flag)
    );

    assign m_tdata = {2'b00, m_flag, m_max, m_right, m_left};

endmodule

`default_nettype wire

// ===== rtl/core/pndc_checker.sv =====
// ----------------------------------------------------------------------------
// pndc_checker
// Port-level checks for the drive controller core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pndc_checker
    import pndc_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic [1:0]            s_tuser,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    // nothing pending right after reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // an evaluate beat makes the block drop s_tready in the cycle after it is taken
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_EVALUATE) |=> !s_tready)
        else $error("input taken right after evaluate beat");

    // speed magnitudes never reach 1024
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:0] != 11'h400) && (m_tdata[21:11] != 11'h400))
        else $error("wheel speed out of range");

endmodule

bind proximity_neural_drive_controller_core pndc_checker u_pndc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the proximity drive controller. Loads the weight
// memory, then runs directed and random load/evaluate beats under several
// register settings with random stalls on both streams. Each result beat is
// checked against a software model of the offset, normalize, perceptron and
// speed stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import pndc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // op code with no function, must be dropped
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct {
        int left_speed;
        int right_speed;
        int max_act;
        int obstacle;
    } drive_t;

    class drive_scoreboard;
        int     weights[WEIGHT_DEPTH_DEF];
        int     offsets[NUM_INPUTS_DEF];
        int     tanh_lut[TANH_ENTRIES_DEF];
        int     hidden_cnt;
        int     recip;
        int     speed_gain;
        int     stop_lvl;
        int     obst_lvl;
        int     errors;
        drive_t pending_drive[$];

        function new();
            for (int i = 0; i < TANH_ENTRIES_DEF; i++) tanh_lut[i] = lut_value(i);
            foreach (offsets[i]) offsets[i] = 0;
            foreach (weights[i]) weights[i] = 0;
            hidden_cnt = 0;
            recip      = 17;
            speed_gain = 1000;
            stop_lvl   = 29491;
            obst_lvl   = 300;
            errors     = 0;
        endfunction

        // round(32768*tanh(4i/N)) via Q30 exp series, squared three times
        function int lut_value(int i);
            longint x;
            longint tk;
            longint acc;
            longint ex;
            longint r;
            x  = (longint'(i) << 30) / TANH_ENTRIES_DEF;
            tk = Q30_ONE;
            acc = Q30_ONE;
            for (int k = 1; k <= 20; k++) begin
                tk = ((tk * x) >>> 30) / k;
                acc = (k % 2) ? acc - tk : acc + tk;
            end
            ex = (acc < 0) ? 0 : acc;
            for (int n = 0; n < 3; n++) ex = (ex * ex) >>> 30;
            r = ((Q30_ONE - ex) * 32768 + (Q30_ONE + ex) / 2) / (Q30_ONE + ex);
            if (r > 32767) r = 32767;
            if (r < 0) r = 0;
            return int'(r);
        endfunction

        function int squash(longint s);
            longint m;
            longint ix;
            int     v;
            m  = (s < 0) ? -s : s;
            ix = ((m >> 15) * TANH_ENTRIES_DEF) >> 14;
            v  = (ix >= TANH_ENTRIES_DEF) ? 32767 : tanh_lut[ix];
            return (s < 0) ? -v : v;
        endfunction

        function int fire(int act[NUM_INPUTS_DEF], int cnt, int base);
            longint s;
            s = 0;
            for (int j = 0; j < cnt; j++)
                s += longint'(act[j]) * weights[(base + j) % WEIGHT_DEPTH_DEF];
            s += longint'(weights[(base + cnt) % WEIGHT_DEPTH_DEF]) * 32768;
            return squash(s);
        endfunction

        function int wheel(int o);
            longint m;
            m = (o < 0) ? -o : o;
            m = (m * speed_gain) >> 15;
            return (o < 0) ? -int'(m) : int'(m);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] ix, int v);
            case (ix)
                CFG_HIDDEN_COUNT: hidden_cnt = v & 'hF;
                CFG_RANGE_RECIP:  recip      = v & 'hFFFF;
                CFG_SPEED_SCALE:  speed_gain = v & 'h3FF;
                CFG_STOP_LEVEL:   stop_lvl   = v & 'h7FFF;
                CFG_OBST_THRESH:  obst_lvl   = v & 'hFFF;
                default: ;
            endcase
        endfunction

        function void note_beat(logic [1:0] op, logic [IN_DATA_W-1:0] d);
            int     act[NUM_INPUTS_DEF];
            int     hid[NUM_INPUTS_DEF];
            int     outv[2];
            int     ix;
            int     h;
            int     dv;
            longint a;
            drive_t r;
            ix = d[IDX_LSB +: 7];
            if (op == OP_LOAD_WEIGHT) begin
                weights[ix % WEIGHT_DEPTH_DEF] = int'($signed(d[VAL_LSB +: 16]));
            end else if (op == OP_LOAD_OFFSET) begin
                if (ix < NUM_INPUTS_DEF) offsets[ix] = d[VAL_LSB +: 12];
            end else if (op == OP_EVALUATE) begin
                r.max_act  = 0;
                r.obstacle = 0;
                for (int j = 0; j < NUM_INPUTS_DEF; j++) begin
                    dv = d[SENSOR_LSB + 12*j +: 12];
                    dv = (dv > offsets[j]) ? dv - offsets[j] : 0;
                    a  = (longint'(dv) * recip) >> 1;
                    if (a > 32767) a = 32767;
                    act[j] = int'(a);
                    if (act[j] > r.max_act) r.max_act = act[j];
                    if (dv > obst_lvl) r.obstacle = 1;
                end
                h = (hidden_cnt > MAX_HIDDEN_DEF) ? MAX_HIDDEN_DEF : hidden_cnt;
                if (h > 0) begin
                    foreach (hid[j]) hid[j] = 0;
                    for (int j = 0; j < h; j++)
                        hid[j] = fire(act, NUM_INPUTS_DEF, j * (NUM_INPUTS_DEF + 1));
                    for (int o = 0; o < 2; o++)
                        outv[o] = fire(hid, h, h * (NUM_INPUTS_DEF + 1) + o * (h + 1));
                end else begin
                    for (int o = 0; o < 2; o++)
                        outv[o] = fire(act, NUM_INPUTS_DEF, o * (NUM_INPUTS_DEF + 1));
                end
                r.left_speed  = wheel(outv[0]);
                r.right_speed = wheel(outv[1]);
                if (r.max_act > stop_lvl) begin
                    r.left_speed  = 0;
                    r.right_speed = 0;
                end
                pending_drive.push_back(r);
            end
        endfunction

        function void check_beat(logic [OUT_DATA_W-1:0] d);
            drive_t e;
            int     l;
            int     rt;
            if (pending_drive.size() == 0) begin
                $error("unexpected result beat %h", d);
                errors++;
                return;
            end
            e  = pending_drive.pop_front();
            l  = int'($signed(d[10:0]));
            rt = int'($signed(d[21:11]));
            if (l != e.left_speed) begin
                $error("left_speed exp %0d got %0d", e.left_speed, l);
                errors++;
            end
            if (rt != e.right_speed) begin
                $error("right_speed exp %0d got %0d", e.right_speed, rt);
                errors++;
            end
            if (int'(d[36:22]) != e.max_act) begin
                $error("max_activation exp %0d got %0d", e.max_act, d[36:22]);
                errors++;
            end
            if (int'(d[37]) != e.obstacle) begin
                $error("obstacle_flag exp %0d got %0d", e.obstacle, d[37]);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 250;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;

    drive_scoreboard sb = new();
    bit  calm;
    int  cycles;

    proximity_neural_drive_controller_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    initial begin
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0; aresetn = 1'b0;
        calm = 1'b0; cycles = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_beat(m_tdata);
            m_tready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    task automatic send(logic [1:0] op, int ix, int val, int sens[NUM_INPUTS_DEF]);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[IDX_LSB +: 7]  = ix[6:0];
        d[VAL_LSB +: 16] = val[15:0];
        for (int j = 0; j < NUM_INPUTS_DEF; j++) d[SENSOR_LSB + 12*j +: 12] = sens[j][11:0];
        if (!calm && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the sender until all results are back, then let the engine settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_drive.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] ix, int v);
        cfg_wr_en <= 1'b1;
        cfg_index <= ix;
        cfg_wdata <= v[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(ix, v);
    endtask

    task automatic set_all(int hc, int rr, int sp, int st, int ob);
        drain();
        write_reg(CFG_HIDDEN_COUNT, hc);
        write_reg(CFG_RANGE_RECIP, rr);
        write_reg(CFG_SPEED_SCALE, sp);
        write_reg(CFG_STOP_LEVEL, st);
        write_reg(CFG_OBST_THRESH, ob);
    endtask

    task automatic eval_const(int v);
        int s[NUM_INPUTS_DEF];
        foreach (s[j]) s[j] = v;
        send(OP_EVALUATE, 0, 0, s);
    endtask

    task automatic random_beat();
        int s[NUM_INPUTS_DEF];
        int k;
        int v;
        foreach (s[j]) s[j] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                           : $urandom_range(0, 700);
        k = $urandom_range(0, 99);
        if (k < 55) begin
            send(OP_EVALUATE, $urandom_range(0, 127), $urandom_range(0, 65535), s);
        end else if (k < 80) begin
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 8191) - 4096;
            send(OP_LOAD_WEIGHT, $urandom_range(0, 127), v, s);
        end else if (k < 95) begin
            v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 400);
            send(OP_LOAD_OFFSET, ($urandom_range(0, 9) == 0) ? $urandom_range(8, 127)
                                                              : $urandom_range(0, 7), v, s);
        end else begin
            send(OP_SPARE, $urandom_range(0, 127), $urandom_range(0, 65535), s);
        end
    endtask

    initial begin
        int s[NUM_INPUTS_DEF];
        foreach (s[j]) s[j] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every weight is written before any evaluate can read it
        for (int a = 0; a < WEIGHT_DEPTH_DEF; a++)
            send(OP_LOAD_WEIGHT, a, (a == 0) ? -32768 : (a == 127) ? 32767
                                  : $urandom_range(0, 8191) - 4096, s);

        // directed: defaults, extremes of sensors, offsets and registers
        eval_const(0);
        eval_const(4095);
        send(OP_LOAD_OFFSET, 3, 'hFFFF, s);
        send(OP_LOAD_OFFSET, 127, 100, s);
        send(OP_SPARE, 5, 5, s);
        eval_const(2000);
        set_all(15, 0, 1023, 32767, 0);
        eval_const(4095);
        eval_const(1);
        set_all(8, 65535, 0, 0, 4095);
        eval_const(4095);
        eval_const(0);
        set_all(0, 40, 1023, 32767, 300);
        eval_const(300);
        eval_const(4095);
        send(OP_LOAD_OFFSET, 3, 0, s);
        set_all(8, 12, 1023, 32767, 2000);
        eval_const(1500);
        eval_const(4095);

        for (int p = 0; p < 6; p++) begin
            set_all(($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(1, 40),
                    $urandom_range(0, 1023),
                    ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32767) : 32767,
                    $urandom_range(0, 4095));
            calm = (p == 2);
            for (int i = 0; i < 50; i++) random_beat();
        end
        calm = 1'b0;

        drain();
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/pndc_pkg.sv
rtl/core/pndc_lane.sv
rtl/core/pndc_merge.sv
rtl/core/pndc_mac.sv
rtl/core/proximity_neural_drive_controller_core.sv
rtl/core/pndc_checker.sv
tb/tb.sv
